/* rtl/core/chm_pkg.sv */
package chm_pkg;

   localparam int MaxHitsDefault = 1024;
   localparam int SearchWindowDefault = 50;

   localparam logic [23:0] InvCQ24 = 24'd5596277;
   localparam logic [23:0] ThresholdReset = 24'd60;
   localparam logic [15:0] WindowReset = 16'd100;

   typedef enum logic [2:0] {
      ST_IGNORED  = 3'd0,
      ST_MERGED   = 3'd1,
      ST_INSERTED = 3'd2,
      ST_FULL     = 3'd3,
      ST_CLEARED  = 3'd4
   } status_type;

   typedef enum logic [0:0] {
      REG_THRESHOLD = 1'b0,
      REG_WINDOW    = 1'b1
   } reg_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SQRT,
      S_FLIGHT,
      S_HTIME,
      S_SETUP,
      S_READ,
      S_CMP,
      S_MERGE,
      S_DECIDE,
      S_OUT
   } state_type;

   typedef struct packed {
      logic        action;
      logic [15:0] crystal;
      logic [31:0] particle_code;
      logic [23:0] energy_kev;
      logic [31:0] global_time_ps;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [15:0] pos_z;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [9:0]  entry_index;
      logic [31:0] entry_energy;
      logic [32:0] entry_time;
      logic [10:0] hit_count;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic [33:0] radicand;
   } sqrt_ctl_type;

   typedef struct packed {
      logic        done;
      logic [16:0] root;
   } sqrt_sts_type;

endpackage

/* rtl/core/chm_if.sv */
interface chm_req_if;
   logic                valid;
   logic                ready;
   chm_pkg::req_type    payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface chm_rsp_if;
   logic                valid;
   logic                ready;
   chm_pkg::rsp_type    payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface chm_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [23:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/core/chm_ram.sv */
module chm_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/core/chm_isqrt.sv */
module chm_isqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  chm_pkg::sqrt_ctl_type ctl,
   output chm_pkg::sqrt_sts_type sts
);
   // Restoring square root, one result bit per cycle over 17 steps.
   logic [33:0] rem_ff, rem_in;
   logic [16:0] root_ff, root_in;
   logic [33:0] src_ff, src_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [35:0] trial;
   logic [35:0] rem_sh;

   always_comb begin
      rem_in  = rem_ff;
      root_in = root_ff;
      src_in  = src_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff, src_ff[33:32]};
      trial   = {17'd0, root_ff, 2'b01};
      if (ctl.start) begin
         rem_in  = '0;
         root_in = '0;
         src_in  = ctl.radicand;
         cnt_in  = 5'd17;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         src_in = {src_ff[31:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = 34'(rem_sh - trial);
            root_in = {root_ff[15:0], 1'b1};
         end else begin
            rem_in  = rem_sh[33:0];
            root_in = {root_ff[15:0], 1'b0};
         end
         cnt_in = 5'(cnt_ff - 5'd1);
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      root_ff <= root_in;
      src_ff  <= src_in;
   end

   assign sts.done = done_ff;
   assign sts.root = root_ff;
endmodule

/* rtl/core/calorimeter_hit_merger_unit.sv */
// Calorimeter hit merger.
// req_ carries one item: a deposit or, with action set, a clear of the hit table.
// rsp_ returns exactly one result item for every request item, in order.
// csr_ writes energy_threshold (index 0) and time_window (index 1) at any
// valid/ready edge; writes beyond the list are accepted and ignored.
// One item is worked on at a time; req_ready is high only when idle.
// A clear or ignored deposit offers its result in the cycle after it is accepted.
// A kept deposit works through the three squares, the bit-serial square
// root and the flight time, then searches table entries one at a time (RAM read,
// then compare), up to SearchWindow entries, newest first, and then merges into
// the first match or, with none, inserts the hit or reports the table full.
// req_ready rises again in the cycle after the result has been taken.
// The entry RAM has one read port, which sets the search pace.
// The result waits in its register while rsp_ready is low; the block does
// not take a new item until it is taken.
// Reset empties the table (count to zero) and restores the register values;
// the RAM contents are left as they are, as only entries below the count are read.
module calorimeter_hit_merger_unit #(
   parameter int MaxHits = chm_pkg::MaxHitsDefault,
   parameter int SearchWindow = chm_pkg::SearchWindowDefault
) (
   input logic clock,
   input logic reset,
   chm_req_if.sink   req_,
   chm_rsp_if.source rsp_,
   chm_csr_if.sink   csr_
);
   localparam int AW = $clog2(MaxHits);
   localparam int CW = $clog2(MaxHits + 1);
   localparam int RW = 16 + 32 + 33 + 32;

   chm_pkg::state_type state_ff, state_in;
   chm_pkg::req_type   item_ff, item_in;
   chm_pkg::rsp_type   rsp_ff, rsp_in;
   logic [23:0]  thr_ff;
   logic [15:0]  win_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] stop_ff, stop_in;
   logic [33:0]  sq_ff, sq_in;
   logic [1:0]   sqs_ff, sqs_in;
   logic [40:0]  prod_ff, prod_in;
   logic [32:0]  htime_ff, htime_in;
   logic         wr_en;
   logic [AW-1:0] wr_addr;
   logic [RW-1:0] wr_data, rd_data;
   logic [AW-1:0] rd_addr;
   chm_pkg::sqrt_ctl_type sctl;
   chm_pkg::sqrt_sts_type ssts;
   logic [15:0]  r_crystal;
   logic [31:0]  r_particle;
   logic [32:0]  r_time;
   logic [31:0]  r_energy;
   logic [33:0]  diff;
   logic [33:0]  adiff;
   logic [32:0]  esum;
   logic [32:0]  sqterm;
   logic [15:0]  sqsel;
   logic [31:0]  sqprod;

   assign csr_.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= chm_pkg::ThresholdReset;
         win_ff <= chm_pkg::WindowReset;
      end else if (csr_.valid) begin
         case (csr_.index)
            chm_pkg::REG_THRESHOLD: thr_ff <= csr_.data;
            chm_pkg::REG_WINDOW:    win_ff <= csr_.data[15:0];
            default: ;
         endcase
      end
   end

   chm_isqrt u_isqrt (.clock(clock), .reset(reset), .ctl(sctl), .sts(ssts));

   chm_ram #(.Width(RW), .Depth(MaxHits)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign {r_crystal, r_particle, r_time, r_energy} = rd_data;
   assign rd_addr = AW'(idx_ff - CW'(1));
   assign diff  = {r_time[32], r_time} - {htime_ff[32], htime_ff};
   assign adiff = diff[33] ? 34'(-diff) : diff;
   assign esum  = {1'b0, r_energy} + {9'd0, item_ff.energy_kev};

   // The three squares share one 16x16 multiplier, one per cycle.
   always_comb begin
      case (sqs_ff)
         2'd0:    sqsel = item_ff.pos_x;
         2'd1:    sqsel = item_ff.pos_y;
         default: sqsel = item_ff.pos_z;
      endcase
   end
   assign sqprod = 32'($signed(sqsel) * $signed(sqsel));
   assign sqterm = {1'b0, sqprod};

   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      rsp_in   = rsp_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      stop_in  = stop_ff;
      sq_in    = sq_ff;
      sqs_in   = sqs_ff;
      prod_in  = prod_ff;
      htime_in = htime_ff;
      sctl     = '0;
      wr_en    = 1'b0;
      wr_addr  = AW'(count_ff);
      wr_data  = {item_ff.crystal, item_ff.particle_code, htime_ff,
                  8'd0, item_ff.energy_kev};
      req_.ready = 1'b0;
      case (state_ff)
         chm_pkg::S_IDLE: begin
            req_.ready = 1'b1;
            if (req_.valid) begin
               item_in = req_.payload;
               rsp_in  = '0;
               sq_in   = '0;
               sqs_in  = '0;
               if (req_.payload.action) begin
                  count_in = '0;
                  rsp_in.status = chm_pkg::ST_CLEARED;
                  state_in = chm_pkg::S_OUT;
               end else if (req_.payload.energy_kev == 24'd0 ||
                            req_.payload.energy_kev < thr_ff) begin
                  rsp_in.status = chm_pkg::ST_IGNORED;
                  rsp_in.hit_count = 11'(count_ff);
                  state_in = chm_pkg::S_OUT;
               end else begin
                  state_in = chm_pkg::S_SQRT;
               end
            end
         end
         chm_pkg::S_SQRT: begin
            if (sqs_ff != 2'd3) begin
               sq_in  = 34'(sq_ff + {1'b0, sqterm});
               sqs_in = 2'(sqs_ff + 2'd1);
               if (sqs_ff == 2'd2) begin
                  sctl.start    = 1'b1;
                  sctl.radicand = 34'(sq_ff + {1'b0, sqterm});
               end
            end else if (ssts.done) begin
               prod_in  = 41'(ssts.root * chm_pkg::InvCQ24);
               state_in = chm_pkg::S_FLIGHT;
            end
         end
         chm_pkg::S_FLIGHT: begin
            prod_in  = 41'(prod_ff + 41'(1 << 23));
            state_in = chm_pkg::S_HTIME;
         end
         chm_pkg::S_HTIME: begin
            htime_in = 33'({1'b0, item_ff.global_time_ps} - {16'd0, prod_ff[40:24]});
            state_in = chm_pkg::S_SETUP;
         end
         chm_pkg::S_SETUP: begin
            idx_in  = count_ff;
            stop_in = (count_ff > CW'(SearchWindow)) ? CW'(count_ff - CW'(SearchWindow))
                                                    : '0;
            state_in = (count_ff == '0) ? chm_pkg::S_DECIDE : chm_pkg::S_READ;
         end
         chm_pkg::S_READ: begin
            state_in = chm_pkg::S_CMP;
         end
         chm_pkg::S_CMP: begin
            if (r_crystal == item_ff.crystal && r_particle == item_ff.particle_code &&
                adiff <= {18'd0, win_ff}) begin
               state_in = chm_pkg::S_MERGE;
            end else begin
               idx_in = CW'(idx_ff - CW'(1));
               state_in = (CW'(idx_ff - CW'(1)) == stop_ff) ? chm_pkg::S_DECIDE
                                                             : chm_pkg::S_READ;
            end
         end
         chm_pkg::S_MERGE: begin
            wr_en   = 1'b1;
            wr_addr = rd_addr;
            wr_data = {r_crystal, r_particle, r_time,
                       esum[32] ? 32'hFFFF_FFFF : esum[31:0]};
            rsp_in.status       = chm_pkg::ST_MERGED;
            rsp_in.entry_index  = 10'(rd_addr);
            rsp_in.entry_energy = esum[32] ? 32'hFFFF_FFFF : esum[31:0];
            rsp_in.entry_time   = r_time;
            rsp_in.hit_count    = 11'(count_ff);
            state_in = chm_pkg::S_OUT;
         end
         chm_pkg::S_DECIDE: begin
            if (count_ff >= CW'(MaxHits)) begin
               rsp_in.status    = chm_pkg::ST_FULL;
               rsp_in.hit_count = 11'(count_ff);
            end else begin
               wr_en = 1'b1;
               rsp_in.status       = chm_pkg::ST_INSERTED;
               rsp_in.entry_index  = 10'(count_ff);
               rsp_in.entry_energy = {8'd0, item_ff.energy_kev};
               rsp_in.entry_time   = htime_ff;
               rsp_in.hit_count    = 11'(count_ff + CW'(1));
               count_in = CW'(count_ff + CW'(1));
            end
            state_in = chm_pkg::S_OUT;
         end
         chm_pkg::S_OUT: begin
            if (rsp_.ready) begin
               state_in = chm_pkg::S_IDLE;
            end
         end
         default: state_in = chm_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= chm_pkg::S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      item_ff  <= item_in;
      rsp_ff   <= rsp_in;
      idx_ff   <= idx_in;
      stop_ff  <= stop_in;
      sq_ff    <= sq_in;
      sqs_ff   <= sqs_in;
      prod_ff  <= prod_in;
      htime_ff <= htime_in;
   end

   assign rsp_.valid   = (state_ff == chm_pkg::S_OUT);
   assign rsp_.payload = rsp_ff;
endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

   localparam int TableDepth = chm_pkg::MaxHitsDefault;
   localparam int SearchDepth = chm_pkg::SearchWindowDefault;

   // Keeps its own copy of the hit table and works out the result of every item.
   class hit_table_scoreboard;
      logic [15:0] table_crystal [TableDepth];
      logic [31:0] table_particle [TableDepth];
      longint table_time [TableDepth];
      logic [31:0] table_energy [TableDepth];
      int table_count;
      logic [23:0] threshold;
      logic [15:0] window;
      chm_pkg::rsp_type awaited[$];
      int mismatches;

      function void restart();
         table_count = 0;
         threshold = chm_pkg::ThresholdReset;
         window = chm_pkg::WindowReset;
         awaited.delete();
         mismatches = 0;
      endfunction

      function void write_register(chm_pkg::reg_index_type idx, logic [23:0] value);
         if (idx == chm_pkg::REG_THRESHOLD) threshold = value;
         else window = value[15:0];
      endfunction

      function longint unsigned root_floor(longint unsigned v);
         longint unsigned res, bv;
         res = 0;
         bv = 64'd1 << 62;
         while (bv > v) bv >>= 2;
         while (bv != 0) begin
            if (v >= res + bv) begin
               v -= res + bv;
               res = (res >> 1) + bv;
            end else begin
               res >>= 1;
            end
            bv >>= 2;
         end
         return res;
      endfunction

      function void note_request(chm_pkg::req_type r);
         chm_pkg::rsp_type e;
         longint x, y, z, hit, diff;
         longint unsigned distance, flight, total;
         int i, first;
         bit found;
         e = '0;
         found = 0;
         if (r.action) begin
            table_count = 0;
            e.status = chm_pkg::ST_CLEARED;
         end else if (r.energy_kev == 0 || r.energy_kev < threshold) begin
            e.status = chm_pkg::ST_IGNORED;
            e.hit_count = 11'(table_count);
         end else begin
            x = longint'(signed'(r.pos_x));
            y = longint'(signed'(r.pos_y));
            z = longint'(signed'(r.pos_z));
            distance = root_floor(x * x + y * y + z * z);
            flight = (distance * 64'(chm_pkg::InvCQ24) + (64'd1 << 23)) >> 24;
            hit = longint'({32'd0, r.global_time_ps}) - longint'(flight);
            first = table_count > SearchDepth ? table_count - SearchDepth : 0;
            for (i = table_count - 1; i >= first && !found; i--) begin
               diff = table_time[i] - hit;
               if (diff < 0) diff = -diff;
               if (table_crystal[i] == r.crystal && table_particle[i] == r.particle_code &&
                   diff <= longint'(window)) begin
                  total = longint'(table_energy[i]) + longint'(r.energy_kev);
                  table_energy[i] = total > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : total[31:0];
                  e.status = chm_pkg::ST_MERGED;
                  e.entry_index = 10'(i);
                  e.entry_energy = table_energy[i];
                  e.entry_time = table_time[i][32:0];
                  found = 1;
               end
            end
            if (!found && table_count >= TableDepth) begin
               e.status = chm_pkg::ST_FULL;
            end else if (!found) begin
               i = table_count;
               table_crystal[i] = r.crystal;
               table_particle[i] = r.particle_code;
               table_time[i] = hit;
               table_energy[i] = {8'd0, r.energy_kev};
               table_count++;
               e.status = chm_pkg::ST_INSERTED;
               e.entry_index = 10'(i);
               e.entry_energy = {8'd0, r.energy_kev};
               e.entry_time = hit[32:0];
            end
            e.hit_count = 11'(table_count);
         end
         if (r.action) e.hit_count = 0;
         awaited.push_back(e);
      endfunction

      function void check_result(chm_pkg::rsp_type got);
         chm_pkg::rsp_type e;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result item %p", got);
            return;
         end
         e = awaited.pop_front();
         if (got.status !== e.status || got.entry_index !== e.entry_index ||
             got.entry_energy !== e.entry_energy || got.entry_time !== e.entry_time ||
             got.hit_count !== e.hit_count) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"Mismatch: expected st=%0d idx=%0d en=%0d t=%h cnt=%0d, ",
                         "got st=%0d idx=%0d en=%0d t=%h cnt=%0d"},
                        e.status, e.entry_index, e.entry_energy, e.entry_time, e.hit_count,
                        got.status, got.entry_index, got.entry_energy, got.entry_time,
                        got.hit_count);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   chm_req_if req_bus();
   chm_rsp_if rsp_bus();
   chm_csr_if csr_bus();
   hit_table_scoreboard board;
   bit steady_sender;
   int holdoff_cycles;

   calorimeter_hit_merger_unit uut (
      .clock(clock),
      .reset(reset),
      .req_(req_bus),
      .rsp_(rsp_bus),
      .csr_(csr_bus)
   );

   initial clock = 0;
   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   initial begin
      #40ms;
      $display("Verification failed");
      $finish;
   end

   // Result side: random stalls, with one long hold-off when asked for.
   initial begin
      int pause;
      rsp_bus.ready <= 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (holdoff_cycles > 0) begin
            pause = holdoff_cycles;
            holdoff_cycles = 0;
         end else begin
            pause = steady_sender ? 0 : $urandom_range(0, 17);
         end
         if (pause > 0) begin
            rsp_bus.ready <= 0;
            repeat (pause) @(posedge clock);
         end
         rsp_bus.ready <= 1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         board.check_result(rsp_bus.payload);
      end
   end

   task automatic send_item(chm_pkg::req_type r);
      int gap;
      gap = steady_sender ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_bus.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1;
      req_bus.payload <= r;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      board.note_request(r);
   endtask

   task automatic settle();
      req_bus.valid <= 0;
      @(posedge clock);
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_register(chm_pkg::reg_index_type idx, logic [23:0] value);
      csr_bus.valid <= 1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 0;
      board.write_register(idx, value);
   endtask

   function automatic chm_pkg::req_type deposit(logic [15:0] crystal, logic [31:0] code,
                                                logic [23:0] energy, logic [31:0] t,
                                                logic [15:0] x, logic [15:0] y,
                                                logic [15:0] z);
      chm_pkg::req_type r;
      r.action = 0;
      r.crystal = crystal;
      r.particle_code = code;
      r.energy_kev = energy;
      r.global_time_ps = t;
      r.pos_x = x;
      r.pos_y = y;
      r.pos_z = z;
      return r;
   endfunction

   function automatic chm_pkg::req_type noise_item();
      logic [191:0] noise;
      chm_pkg::req_type r;
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      r = noise[$bits(chm_pkg::req_type)-1:0];
      return r;
   endfunction

   function automatic chm_pkg::req_type clear_item();
      chm_pkg::req_type r;
      r = noise_item();
      r.action = 1;
      return r;
   endfunction

   // Mostly a few crystals and particle codes near a common time so that merges happen.
   function automatic chm_pkg::req_type random_item(logic [31:0] base_time);
      chm_pkg::req_type r;
      logic [31:0] codes [4];
      codes = '{32'd11, -32'sd11, 32'd22, 32'd2112};
      if ($urandom_range(0, 99) < 3) return clear_item();
      r = noise_item();
      r.action = 0;
      if ($urandom_range(0, 3) != 0) begin
         r.crystal = 16'($urandom_range(0, 7));
         r.particle_code = codes[$urandom_range(0, 3)];
         r.global_time_ps = base_time + $urandom_range(0, 300);
         r.pos_x = 16'($urandom_range(0, 200));
         r.pos_y = 16'($urandom_range(0, 200));
         r.pos_z = 16'($urandom_range(0, 200));
         if ($urandom_range(0, 1)) r.energy_kev = 24'($urandom_range(0, 5000));
      end
      if ($urandom_range(0, 19) == 0) r.energy_kev = 0;
      return r;
   endfunction

   initial begin
      int n;
      logic [31:0] base;
      board = new();
      board.restart();
      steady_sender = 0;
      holdoff_cycles = 0;
      reset <= 1;
      req_bus.valid <= 0;
      req_bus.payload <= '0;
      csr_bus.valid <= 0;
      csr_bus.index <= chm_pkg::REG_THRESHOLD;
      csr_bus.data <= '0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed items at the reset register values.
      send_item(clear_item());
      send_item(deposit(16'd1, 32'd11, 24'd0, 32'd1000, 16'd0, 16'd0, 16'd0));
      send_item(deposit(16'd1, 32'd11, 24'd59, 32'd1000, 16'd0, 16'd0, 16'd0));
      send_item(deposit(16'd1, 32'd11, 24'd60, 32'd1000, 16'd0, 16'd0, 16'd0));
      send_item(deposit(16'd1, 32'd11, 24'd70, 32'd1100, 16'd0, 16'd0, 16'd0));
      send_item(deposit(16'd1, 32'd11, 24'd70, 32'd899, 16'd0, 16'd0, 16'd0));
      send_item(deposit(16'd1, 32'd11, 24'd70, 32'd1101, 16'd0, 16'd0, 16'd0));
      send_item(deposit(16'd65535, 32'h7FFF_FFFF, 24'hFFFFFF, 32'd0,
                        16'h8000, 16'h8000, 16'h8000));
      send_item(deposit(16'd65535, 32'h8000_0000, 24'hFFFFFF, 32'hFFFF_FFFF,
                        16'h7FFF, 16'h7FFF, 16'h7FFF));
      send_item(deposit(16'd65535, 32'h8000_0000, 24'd100, 32'hFFFF_FFF0,
                        16'h7FFF, 16'h7FFF, 16'h7FFF));
      send_item(deposit(16'd0, 32'hFFFF_FFFF, 24'd61, 32'd5, 16'hFFFF, 16'd1, 16'h8000));
      send_item(deposit(16'd1, 32'd11, 24'd80, 32'd1050, 16'd0, 16'd0, 16'd0));
      send_item(clear_item());
      send_item(deposit(16'd2, 32'd22, 24'd90, 32'd40, 16'd300, 16'd400, 16'd0));
      send_item(deposit(16'd2, 32'd22, 24'd90, 32'd40, 16'd300, 16'd400, 16'd0));
      settle();

      // Widest window, no threshold; the result side holds off for a while.
      write_register(chm_pkg::REG_THRESHOLD, 24'd0);
      write_register(chm_pkg::REG_WINDOW, 24'hFFFF);
      base = $urandom;
      for (n = 0; n < 250; n++) begin
         if (n == 60) holdoff_cycles = 600;
         if (n % 50 == 0) steady_sender = ($urandom_range(0, 3) == 0);
         send_item(random_item(base));
      end
      steady_sender = 0;
      settle();

      // Fill the table past its size; zero window keeps distinct entries apart.
      write_register(chm_pkg::REG_THRESHOLD, 24'd1);
      write_register(chm_pkg::REG_WINDOW, 24'd0);
      send_item(clear_item());
      for (n = 0; n < TableDepth + 6; n++)
         send_item(deposit(n[15:0], $urandom, 24'($urandom_range(1, 24'hFFFFFF)),
                           $urandom, 16'($urandom), 16'($urandom), 16'($urandom)));
      send_item(deposit(16'd1020, board.table_particle[1020], 24'd5,
                        32'd0, 16'd0, 16'd0, 16'd0));
      settle();

      // Highest threshold: only full-scale deposits survive, piling up to saturation.
      write_register(chm_pkg::REG_THRESHOLD, 24'hFFFFFF);
      send_item(clear_item());
      for (n = 0; n < 20; n++) send_item(random_item($urandom));
      steady_sender = 1;
      for (n = 0; n < 300; n++)
         send_item(deposit(16'd77, 32'd13, 24'hFFFFFF, 32'd5000, 16'd10, 16'd20, 16'd30));
      steady_sender = 0;
      settle();

      for (int phase = 0; phase < 3; phase++) begin
         write_register(chm_pkg::REG_THRESHOLD, 24'($urandom_range(0, 3000)));
         write_register(chm_pkg::REG_WINDOW, 24'($urandom_range(0, 400)));
         base = $urandom;
         for (n = 0; n < 70; n++) send_item(random_item(base));
         settle();
      end

      repeat (200) @(posedge clock);
      if (board.mismatches == 0 && board.awaited.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
